// ===== rtl/bma_pkg.sv =====
package bma_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int unsigned TRACK_SLOTS_DEF   = 64;
    localparam int unsigned HISTORY_DEPTH_DEF = 16;

    // Configuration port address width (five word registers).
    localparam int unsigned APB_AW = 5;

    // Q1.16 weight of one.
    localparam logic [16:0] FULL_WEIGHT = 17'd65536;

    // Shared multiply-accumulate unit widths.
    localparam int unsigned MAC_AW = 37;
    localparam int unsigned MAC_BW = 18;
    localparam int unsigned MAC_PW = MAC_AW + MAC_BW;
    localparam int unsigned ACC_W  = 72;

    // Accumulator operations.
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;
    localparam logic [1:0] ACC_SUB  = 2'd3;

    // Shift applied to the product before it enters the accumulator.
    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_8  = 2'd1;
    localparam logic [1:0] SH_16 = 2'd2;
    localparam logic [1:0] SH_17 = 2'd3;

    typedef struct packed {
        logic signed [MAC_AW-1:0] a;
        logic signed [MAC_BW-1:0] b;
        logic [1:0]               acc_op;
        logic [1:0]               sh;
    } mac_op_t;

    typedef struct packed {
        logic        enable;
        logic [16:0] reduced_weight;
        logic [15:0] jump_threshold;
        logic [15:0] shrink_ratio;
        logic [4:0]  history_length;
    } cfg_t;

    // One history entry: doubled center and signed size.
    typedef struct packed {
        logic [16:0]        cx2;
        logic [16:0]        cy2;
        logic signed [16:0] w;
        logic signed [16:0] h;
    } hist_entry_t;

endpackage

// ===== rtl/bma_ram.sv =====
module bma_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bma_mac.sv =====
module bma_mac (
    input  logic                                 clk,
    input  bma_pkg::mac_op_t                     op,
    output logic signed [bma_pkg::MAC_PW-1:0]    p,
    output logic signed [bma_pkg::ACC_W-1:0]     acc
);

    logic signed [bma_pkg::MAC_PW-1:0] p_reg;
    logic signed [bma_pkg::MAC_PW-1:0] p_next;
    logic signed [bma_pkg::ACC_W-1:0]  acc_reg;
    logic signed [bma_pkg::ACC_W-1:0]  acc_next;
    logic signed [bma_pkg::ACC_W-1:0]  p_ext;
    logic signed [bma_pkg::ACC_W-1:0]  p_sh;

    // The product is registered; the accumulator consumes the registered product.
    assign p_next = op.a * op.b;
    assign p_ext  = bma_pkg::ACC_W'(p_reg);

    always_comb
    begin
        unique case (op.sh)
            bma_pkg::SH_0:  p_sh = p_ext;
            bma_pkg::SH_8:  p_sh = p_ext <<< 8;
            bma_pkg::SH_16: p_sh = p_ext <<< 16;
            bma_pkg::SH_17: p_sh = p_ext <<< 17;
            default:        p_sh = p_ext;
        endcase
    end

    always_comb
    begin
        unique case (op.acc_op)
            bma_pkg::ACC_HOLD: acc_next = acc_reg;
            bma_pkg::ACC_LOAD: acc_next = p_sh;
            bma_pkg::ACC_ADD:  acc_next = acc_reg + p_sh;
            bma_pkg::ACC_SUB:  acc_next = acc_reg - p_sh;
            default:           acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        acc_reg <= acc_next;
    end

    assign p   = p_reg;
    assign acc = acc_reg;

endmodule

// ===== rtl/bma_regs.sv =====
module bma_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bma_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output bma_pkg::cfg_t               cfg
);

    localparam logic [2:0] REG_ENABLE    = 3'd0;
    localparam logic [2:0] REG_REDUCED   = 3'd1;
    localparam logic [2:0] REG_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_SHRINK    = 3'd3;
    localparam logic [2:0] REG_LENGTH    = 3'd4;

    bma_pkg::cfg_t cfg_reg;
    logic [2:0]    index;
    logic          wr;

    assign index  = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable         <= 1'b0;
            cfg_reg.reduced_weight <= 17'd32768;
            cfg_reg.jump_threshold <= 16'd512;
            cfg_reg.shrink_ratio   <= 16'd256;
            cfg_reg.history_length <= 5'd8;
        end
        else if (wr)
        begin
            unique case (index)
                REG_ENABLE:    cfg_reg.enable         <= pwdata[0];
                REG_REDUCED:   cfg_reg.reduced_weight <= pwdata[16:0];
                REG_THRESHOLD: cfg_reg.jump_threshold <= pwdata[15:0];
                REG_SHRINK:    cfg_reg.shrink_ratio   <= pwdata[15:0];
                REG_LENGTH:    cfg_reg.history_length <= pwdata[4:0];
                default:       cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_ENABLE:    prdata = {31'd0, cfg_reg.enable};
            REG_REDUCED:   prdata = {15'd0, cfg_reg.reduced_weight};
            REG_THRESHOLD: prdata = {16'd0, cfg_reg.jump_threshold};
            REG_SHRINK:    prdata = {16'd0, cfg_reg.shrink_ratio};
            REG_LENGTH:    prdata = {27'd0, cfg_reg.history_length};
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/box_motion_anomaly_alpha.sv =====
// A box update on a slot that holds two or more boxes walks the history and works out
// both halves of the weight; a shorter history, a clear or a disabled block skips that.
// One item at a time: no new item is accepted until the result of the last one has
// loaded into the output register, and that load waits while an earlier result waits.
// Reset: asynchronous, active low. After reset the per-slot fill/pointer memory is
// swept to zero slot by slot, during which no item is accepted.
module box_motion_anomaly_alpha #(
    parameter int unsigned TRACK_SLOTS   = bma_pkg::TRACK_SLOTS_DEF,
    parameter int unsigned HISTORY_DEPTH = bma_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bma_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // Input item channel.
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        mode,
    input  logic [5:0]                  track_slot,
    input  logic [15:0]                 left_x,
    input  logic [15:0]                 top_y,
    input  logic [15:0]                 right_x,
    input  logic [15:0]                 bottom_y,
    // Result item channel.
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [5:0]                  slot_echo,
    output logic [16:0]                 blend_weight
);

    // Slot index, ring position and fill count widths.
    localparam int unsigned SW   = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
    localparam int unsigned SXW  = (SW > 6) ? SW : 6;
    localparam int unsigned PW   = $clog2(HISTORY_DEPTH);
    localparam int unsigned FW   = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned NNW  = 2 * FW;
    localparam int unsigned HDEP = TRACK_SLOTS * (1 << PW);
    localparam int unsigned HW   = $bits(bma_pkg::hist_entry_t);

    typedef struct packed {
        logic [FW-1:0] fill;
        logic [PW-1:0] oldest;
    } meta_t;

    localparam int unsigned MW = $bits(meta_t);

    // Sequencer states. The Q states run twice: once for the center half,
    // once for the size half of the weight.
    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_META = 5'd2;
    localparam logic [4:0] S_H1   = 5'd3;
    localparam logic [4:0] S_H2   = 5'd4;
    localparam logic [4:0] S_H3   = 5'd5;
    localparam logic [4:0] S_Q0   = 5'd6;
    localparam logic [4:0] S_Q1   = 5'd7;
    localparam logic [4:0] S_Q2   = 5'd8;
    localparam logic [4:0] S_Q3   = 5'd9;
    localparam logic [4:0] S_Q4   = 5'd10;
    localparam logic [4:0] S_Q5   = 5'd11;
    localparam logic [4:0] S_Q6   = 5'd12;
    localparam logic [4:0] S_Q7   = 5'd13;
    localparam logic [4:0] S_Q8   = 5'd14;
    localparam logic [4:0] S_Q9   = 5'd15;
    localparam logic [4:0] S_Q10  = 5'd16;
    localparam logic [4:0] S_FIN  = 5'd17;
    localparam logic [4:0] S_OUT  = 5'd18;

    bma_pkg::cfg_t    cfg;
    bma_pkg::mac_op_t mac_op;
    logic signed [bma_pkg::MAC_PW-1:0] mac_p;
    logic signed [bma_pkg::ACC_W-1:0]  mac_acc;

    logic [4:0]    state_reg, state_next;
    logic [SW-1:0] clr_cnt_reg, clr_cnt_next;

    // Latched item.
    logic [5:0]         slot_reg, slot_next;
    logic [SW-1:0]      sidx_reg, sidx_next;
    logic               mode_reg, mode_next;
    logic               in_range_reg, in_range_next;
    logic [16:0]        cx2_reg, cx2_next;
    logic [16:0]        cy2_reg, cy2_next;
    logic signed [16:0] w_reg, w_next;
    logic signed [16:0] h_reg, h_next;

    // Working state.
    logic [FW-1:0]        fill_reg, fill_next;
    logic [PW-1:0]        oldest_reg, oldest_next;
    logic [FW-1:0]        idx_reg, idx_next;
    bma_pkg::hist_entry_t first_reg, first_next;
    bma_pkg::hist_entry_t last_reg, last_next;
    logic signed [16:0]   eh_reg, eh_next;
    logic                 half_reg, half_next;
    logic                 jump_c_reg, jump_c_next;
    logic                 jump_a_reg, jump_a_next;
    logic                 area_ok_reg, area_ok_next;
    logic [35:0]          c_reg, c_next;
    logic [35:0]          m_reg, m_next;
    logic [NNW-1:0]       nn_reg, nn_next;
    logic [33:0]          kk_reg, kk_next;
    logic [16:0]          weight_reg, weight_next;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic [5:0]  slot_out_reg, slot_out_next;
    logic [16:0] weight_out_reg, weight_out_next;

    // Memories.
    logic                 meta_we;
    logic [SW-1:0]        meta_waddr, meta_raddr;
    meta_t                meta_wdata, meta_rdata;
    logic [MW-1:0]        meta_rbits;
    logic                 hist_we;
    logic [SW+PW-1:0]     hist_waddr, hist_raddr;
    bma_pkg::hist_entry_t hist_wdata, hist_rdata;
    logic [HW-1:0]        hist_rbits;

    // Item acceptance and helpers.
    logic               accept;
    logic [SXW-1:0]     in_slot_ext;
    logic signed [16:0] in_w, in_h;
    logic [FW-1:0]      len_c;
    logic [FW:0]        ring_sum;
    logic [PW-1:0]      ring_pos;
    logic [FW-1:0]      ring_off;
    logic [PW:0]        inc_sum;
    logic [PW-1:0]      oldest_inc;
    logic [FW-1:0]      n_val;
    logic [16:0]        k_val;
    logic signed [17:0] dc0, dc1, dm0, dm1;
    logic [16:0]        half_c, half_a;
    logic [17:0]        wsum;
    logic               acc_pos, acc_nonneg;

    bma_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bma_mac u_mac (
        .clk (clk),
        .op  (mac_op),
        .p   (mac_p),
        .acc (mac_acc)
    );

    // Per-slot fill count and oldest pointer.
    bma_ram #(
        .WIDTH (MW),
        .DEPTH (TRACK_SLOTS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rbits)
    );

    // Box history, addressed by slot and ring position.
    bma_ram #(
        .WIDTH (HW),
        .DEPTH (HDEP)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rbits)
    );

    assign meta_rdata = meta_rbits;
    assign hist_rdata = hist_rbits;

    assign in_stall     = (state_reg != S_IDLE);
    assign accept       = in_valid && !in_stall;
    assign out_valid    = out_valid_reg;
    assign slot_echo    = slot_out_reg;
    assign blend_weight = weight_out_reg;

    assign in_slot_ext = SXW'(track_slot);
    assign in_w = $signed({1'b0, right_x}) - $signed({1'b0, left_x});
    assign in_h = $signed({1'b0, bottom_y}) - $signed({1'b0, top_y});

    // History length is clamped into one to the ring depth.
    always_comb
    begin
        if (cfg.history_length == 5'd0)
        begin
            len_c = FW'(1);
        end
        else if (32'(cfg.history_length) > 32'(HISTORY_DEPTH))
        begin
            len_c = FW'(HISTORY_DEPTH);
        end
        else
        begin
            len_c = FW'(cfg.history_length);
        end
    end

    // Ring position of the entry that lies ring_off places after the oldest one.
    assign ring_off = (state_reg == S_FIN) ? fill_reg : (idx_reg + FW'(1));
    assign ring_sum = (FW+1)'(oldest_reg) + (FW+1)'(ring_off);
    assign ring_pos = (ring_sum >= (FW+1)'(HISTORY_DEPTH)) ?
                      PW'(ring_sum - (FW+1)'(HISTORY_DEPTH)) : PW'(ring_sum);
    assign inc_sum    = (PW+1)'(oldest_reg) + (PW+1)'(1);
    assign oldest_inc = (inc_sum >= (PW+1)'(HISTORY_DEPTH)) ?
                        PW'(inc_sum - (PW+1)'(HISTORY_DEPTH)) : PW'(inc_sum);

    assign n_val = fill_reg - FW'(1);
    assign k_val = 17'd256 + 17'(cfg.jump_threshold);

    // Step of the new box against the newest entry, and the span of the history.
    // The center half works on doubled centers, the size half on width and height.
    always_comb
    begin
        if (!half_reg)
        begin
            dc0 = $signed({1'b0, cx2_reg}) - $signed({1'b0, last_reg.cx2});
            dc1 = $signed({1'b0, cy2_reg}) - $signed({1'b0, last_reg.cy2});
            dm0 = $signed({1'b0, last_reg.cx2}) - $signed({1'b0, first_reg.cx2});
            dm1 = $signed({1'b0, last_reg.cy2}) - $signed({1'b0, first_reg.cy2});
        end
        else
        begin
            dc0 = 18'(w_reg) - 18'(last_reg.w);
            dc1 = 18'(h_reg) - 18'(last_reg.h);
            dm0 = 18'(last_reg.w) - 18'(first_reg.w);
            dm1 = 18'(last_reg.h) - 18'(first_reg.h);
        end
    end

    assign acc_nonneg = !mac_acc[bma_pkg::ACC_W-1];
    assign acc_pos    = acc_nonneg && (mac_acc != '0);

    assign half_c = jump_c_reg ? cfg.reduced_weight : bma_pkg::FULL_WEIGHT;
    assign half_a = jump_a_reg ? cfg.reduced_weight : bma_pkg::FULL_WEIGHT;
    assign wsum   = {1'b0, half_c} + {1'b0, half_a} + 18'd1;

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        slot_next       = slot_reg;
        sidx_next       = sidx_reg;
        mode_next       = mode_reg;
        in_range_next   = in_range_reg;
        cx2_next        = cx2_reg;
        cy2_next        = cy2_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        fill_next       = fill_reg;
        oldest_next     = oldest_reg;
        idx_next        = idx_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        eh_next         = eh_reg;
        half_next       = half_reg;
        jump_c_next     = jump_c_reg;
        jump_a_next     = jump_a_reg;
        area_ok_next    = area_ok_reg;
        c_next          = c_reg;
        m_next          = m_reg;
        nn_next         = nn_reg;
        kk_next         = kk_reg;
        weight_next     = weight_reg;
        out_valid_next  = out_valid_reg;
        slot_out_next   = slot_out_reg;
        weight_out_next = weight_out_reg;

        mac_op.a      = '0;
        mac_op.b      = '0;
        mac_op.acc_op = bma_pkg::ACC_HOLD;
        mac_op.sh     = bma_pkg::SH_0;

        meta_we    = 1'b0;
        meta_waddr = sidx_reg;
        meta_wdata = '0;
        meta_raddr = sidx_reg;
        hist_we    = 1'b0;
        hist_waddr = {sidx_reg, ring_pos};
        hist_wdata = {cx2_reg, cy2_reg, w_reg, h_reg};
        hist_raddr = {sidx_reg, ring_pos};

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR:
            begin
                meta_we    = 1'b1;
                meta_waddr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + SW'(1);
                if (clr_cnt_reg == SW'(TRACK_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                // The slot's metadata is fetched and the new area formed right away.
                meta_raddr = in_slot_ext[SW-1:0];
                mac_op.a   = bma_pkg::MAC_AW'(in_w);
                mac_op.b   = bma_pkg::MAC_BW'(in_h);
                if (accept)
                begin
                    slot_next     = track_slot;
                    sidx_next     = in_slot_ext[SW-1:0];
                    mode_next     = mode;
                    in_range_next = (32'(track_slot) < 32'(TRACK_SLOTS));
                    cx2_next      = 17'(left_x) + 17'(right_x);
                    cy2_next      = 17'(top_y) + 17'(bottom_y);
                    w_next        = in_w;
                    h_next        = in_h;
                    state_next    = S_META;
                end
            end

            S_META:
            begin
                fill_next    = meta_rdata.fill;
                oldest_next  = meta_rdata.oldest;
                idx_next     = '0;
                half_next    = 1'b0;
                weight_next  = bma_pkg::FULL_WEIGHT;
                area_ok_next = 1'b0;
                // Scale the new area by the fill count; read the oldest entry.
                mac_op.a   = mac_p[bma_pkg::MAC_AW-1:0];
                mac_op.b   = bma_pkg::MAC_BW'(meta_rdata.fill);
                hist_raddr = {sidx_reg, meta_rdata.oldest};
                priority if (!in_range_reg)
                begin
                    state_next = S_OUT;
                end
                else if (mode_reg)
                begin
                    meta_we    = 1'b1;
                    state_next = S_OUT;
                end
                else if (!cfg.enable || cfg.reduced_weight[16])
                begin
                    state_next = S_OUT;
                end
                else if (meta_rdata.fill < FW'(2))
                begin
                    // Too short a history: full weight, the box is still appended.
                    area_ok_next = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    state_next = S_H1;
                end
            end

            S_H1:
            begin
                // The accumulator starts with the scaled new area and then loses
                // each history area times the shrink ratio.
                if (idx_reg == '0)
                begin
                    mac_op.acc_op = bma_pkg::ACC_LOAD;
                    mac_op.sh     = bma_pkg::SH_8;
                    first_next    = hist_rdata;
                end
                else
                begin
                    mac_op.acc_op = bma_pkg::ACC_SUB;
                end
                if (idx_reg == n_val)
                begin
                    last_next = hist_rdata;
                end
                eh_next    = hist_rdata.h;
                mac_op.a   = bma_pkg::MAC_AW'(hist_rdata.w);
                mac_op.b   = bma_pkg::MAC_BW'(cfg.shrink_ratio);
                state_next = S_H2;
            end

            S_H2:
            begin
                mac_op.a = mac_p[bma_pkg::MAC_AW-1:0];
                mac_op.b = bma_pkg::MAC_BW'(eh_reg);
                if (idx_reg + FW'(1) < fill_reg)
                begin
                    idx_next   = idx_reg + FW'(1);
                    state_next = S_H1;
                end
                else
                begin
                    state_next = S_H3;
                end
            end

            S_H3:
            begin
                mac_op.acc_op = bma_pkg::ACC_SUB;
                state_next    = S_Q0;
            end

            S_Q0:
            begin
                if (!half_reg)
                begin
                    area_ok_next = acc_nonneg;
                end
                mac_op.a   = bma_pkg::MAC_AW'(dc0);
                mac_op.b   = dc0;
                state_next = S_Q1;
            end

            S_Q1:
            begin
                mac_op.acc_op = bma_pkg::ACC_LOAD;
                mac_op.a      = bma_pkg::MAC_AW'(dc1);
                mac_op.b      = dc1;
                state_next    = S_Q2;
            end

            S_Q2:
            begin
                mac_op.acc_op = bma_pkg::ACC_ADD;
                mac_op.a      = bma_pkg::MAC_AW'(dm0);
                mac_op.b      = dm0;
                state_next    = S_Q3;
            end

            S_Q3:
            begin
                c_next        = mac_acc[35:0];
                mac_op.acc_op = bma_pkg::ACC_LOAD;
                mac_op.a      = bma_pkg::MAC_AW'(dm1);
                mac_op.b      = dm1;
                state_next    = S_Q4;
            end

            S_Q4:
            begin
                mac_op.acc_op = bma_pkg::ACC_ADD;
                mac_op.a      = bma_pkg::MAC_AW'(n_val);
                mac_op.b      = bma_pkg::MAC_BW'(n_val);
                state_next    = S_Q5;
            end

            S_Q5:
            begin
                m_next     = mac_acc[35:0];
                nn_next    = mac_p[NNW-1:0];
                mac_op.a   = bma_pkg::MAC_AW'(k_val);
                mac_op.b   = bma_pkg::MAC_BW'(k_val);
                state_next = S_Q6;
            end

            S_Q6:
            begin
                kk_next    = mac_p[33:0];
                mac_op.a   = bma_pkg::MAC_AW'(c_reg);
                mac_op.b   = bma_pkg::MAC_BW'(nn_reg);
                state_next = S_Q7;
            end

            S_Q7:
            begin
                // Step times n squared, in Q.16, minus span times (1 + T) squared.
                mac_op.acc_op = bma_pkg::ACC_LOAD;
                mac_op.sh     = bma_pkg::SH_16;
                mac_op.a      = bma_pkg::MAC_AW'(m_reg);
                mac_op.b      = {1'b0, kk_reg[16:0]};
                state_next    = S_Q8;
            end

            S_Q8:
            begin
                mac_op.acc_op = bma_pkg::ACC_SUB;
                mac_op.a      = bma_pkg::MAC_AW'(m_reg);
                mac_op.b      = {1'b0, kk_reg[33:17]};
                state_next    = S_Q9;
            end

            S_Q9:
            begin
                mac_op.acc_op = bma_pkg::ACC_SUB;
                mac_op.sh     = bma_pkg::SH_17;
                state_next    = S_Q10;
            end

            S_Q10:
            begin
                if (!half_reg)
                begin
                    jump_c_next = acc_pos;
                    half_next   = 1'b1;
                    state_next  = S_Q0;
                end
                else
                begin
                    jump_a_next = acc_pos;
                    state_next  = S_FIN;
                end
            end

            S_FIN:
            begin
                weight_next = area_ok_reg ? bma_pkg::FULL_WEIGHT : wsum[17:1];
                hist_we     = 1'b1;
                meta_we     = 1'b1;
                if (fill_reg >= len_c)
                begin
                    meta_wdata.fill   = fill_reg;
                    meta_wdata.oldest = oldest_inc;
                end
                else
                begin
                    meta_wdata.fill   = fill_reg + FW'(1);
                    meta_wdata.oldest = oldest_reg;
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    slot_out_next   = slot_reg;
                    weight_out_next = weight_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg       <= slot_next;
        sidx_reg       <= sidx_next;
        mode_reg       <= mode_next;
        in_range_reg   <= in_range_next;
        cx2_reg        <= cx2_next;
        cy2_reg        <= cy2_next;
        w_reg          <= w_next;
        h_reg          <= h_next;
        fill_reg       <= fill_next;
        oldest_reg     <= oldest_next;
        idx_reg        <= idx_next;
        first_reg      <= first_next;
        last_reg       <= last_next;
        eh_reg         <= eh_next;
        half_reg       <= half_next;
        jump_c_reg     <= jump_c_next;
        jump_a_reg     <= jump_a_next;
        area_ok_reg    <= area_ok_next;
        c_reg          <= c_next;
        m_reg          <= m_next;
        nn_reg         <= nn_next;
        kk_reg         <= kk_next;
        weight_reg     <= weight_next;
        slot_out_reg   <= slot_out_next;
        weight_out_reg <= weight_out_next;
    end

    // An accepted item always makes the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("block not busy after accepting an item");

    // A weight never exceeds one.
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (blend_weight <= bma_pkg::FULL_WEIGHT))
        else $error("blend weight above one");

    // The fill count written back never exceeds the ring depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        meta_we |-> (32'(meta_wdata.fill) <= 32'(HISTORY_DEPTH)))
        else $error("fill count beyond ring depth");

    // A new result is loaded only in the output state, and a waiting one is never lost.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Boxes go in on the input channel; each item makes exactly one weight come back.
    // A local copy of the per-slot box histories works out the expected weight of every
    // accepted item, and the monitor checks results in order against that queue.

    // Register indexes on the configuration port (byte address is four times this).
    localparam int REG_ENABLE    = 0;
    localparam int REG_REDUCED   = 1;
    localparam int REG_THRESHOLD = 2;
    localparam int REG_SHRINK    = 3;
    localparam int REG_LENGTH    = 4;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    localparam int SLOTS       = 64;
    localparam int DEPTH       = 16;
    localparam int WATCHDOG    = 4000;
    localparam int HOLD_CYCLES = 300;
    // Settle time after a drain, longer than the worst latency of one item.
    localparam int SETTLE      = 80;

    typedef struct {
        logic        mode;
        logic [5:0]  slot;
        logic [15:0] lx;
        logic [15:0] ty;
        logic [15:0] rx;
        logic [15:0] by;
    } box_item_t;

    typedef struct {
        logic [5:0]  slot;
        logic [16:0] weight;
    } weight_item_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [bma_pkg::APB_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [5:0]  track_slot;
    logic [15:0] left_x;
    logic [15:0] top_y;
    logic [15:0] right_x;
    logic [15:0] bottom_y;
    logic        out_valid;
    logic        out_stall;
    logic [5:0]  slot_echo;
    logic [16:0] blend_weight;

    box_motion_anomaly_alpha i_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .track_slot(track_slot), .left_x(left_x), .top_y(top_y),
        .right_x(right_x), .bottom_y(bottom_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .slot_echo(slot_echo), .blend_weight(blend_weight)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Shadow of the block: configuration, and per slot the box ring with its
    // fill count and oldest position. Entries hold doubled center and signed size.
    logic        shadow_en;
    int          shadow_reduced;
    int          shadow_thresh;
    int          shadow_shrink;
    int          shadow_length;
    longint      ring_cx[SLOTS][DEPTH];
    longint      ring_cy[SLOTS][DEPTH];
    longint      ring_w[SLOTS][DEPTH];
    longint      ring_h[SLOTS][DEPTH];
    int          ring_fill[SLOTS];
    int          ring_oldest[SLOTS];

    box_item_t    pending_boxes[$];
    weight_item_t expected_weights[$];
    int           queued_count;
    int           accepted_count;
    int           result_count;
    int           error_count;
    int           idle_cycles;
    bit           dense_mode;

    function automatic longint unsigned mag_sq(longint x, longint y);
        return longint'(x * x + y * y);
    endfunction

    // A half of the weight is reduced when the squared new step, scaled by n^2,
    // exceeds the squared mean step scaled by the threshold. Needs 128 bits.
    function automatic bit step_jumps(longint unsigned cur, longint unsigned mean,
                                      longint unsigned n);
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [127:0] k;
        k   = 128'(256 + shadow_thresh);
        lhs = 128'(cur) * 128'(n) * 128'(n) * 128'd65536;
        rhs = 128'(mean) * k * k;
        return lhs > rhs;
    endfunction

    // Works out the weight for one accepted item and advances the slot's ring.
    function automatic logic [16:0] blend_for_box(box_item_t it);
        int     s;
        int     fill;
        int     len;
        int     old;
        int     last;
        int     pos;
        int     half_c;
        int     half_a;
        int     weight;
        longint cx;
        longint cy;
        longint w;
        longint h;
        longint n;
        longint area_sum;
        longint new_area;
        s = it.slot;
        if (it.mode == MODE_CLEAR)
        begin
            ring_fill[s]   = 0;
            ring_oldest[s] = 0;
            return bma_pkg::FULL_WEIGHT;
        end
        if (!shadow_en || shadow_reduced >= 65536)
            return bma_pkg::FULL_WEIGHT;
        cx = longint'(it.lx) + longint'(it.rx);
        cy = longint'(it.ty) + longint'(it.by);
        w  = longint'(it.rx) - longint'(it.lx);
        h  = longint'(it.by) - longint'(it.ty);
        fill = ring_fill[s];
        old  = ring_oldest[s];
        len  = shadow_length < 1 ? 1 : (shadow_length > DEPTH ? DEPTH : shadow_length);
        weight = 65536;
        if (fill >= 2)
        begin
            last = (old + fill - 1) % DEPTH;
            n    = fill - 1;
            half_c = step_jumps(mag_sq(cx - ring_cx[s][last], cy - ring_cy[s][last]),
                                mag_sq(ring_cx[s][last] - ring_cx[s][old],
                                       ring_cy[s][last] - ring_cy[s][old]), n)
                     ? shadow_reduced : 65536;
            half_a = step_jumps(mag_sq(w - ring_w[s][last], h - ring_h[s][last]),
                                mag_sq(ring_w[s][last] - ring_w[s][old],
                                       ring_h[s][last] - ring_h[s][old]), n)
                     ? shadow_reduced : 65536;
            weight = (half_c + half_a + 1) >> 1;
            area_sum = 0;
            for (int i = 0; i < fill; i++)
            begin
                pos = (old + i) % DEPTH;
                area_sum += ring_w[s][pos] * ring_h[s][pos];
            end
            new_area = w * h;
            if (new_area * 256 * fill >= area_sum * shadow_shrink)
                weight = 65536;
        end
        // A full ring drops its oldest box; the write covers both the old head
        // and the new tail, which coincide when the ring holds sixteen boxes.
        if (fill >= len)
        begin
            pos = (old + fill) % DEPTH;
            ring_cx[s][old] = cx;  ring_cy[s][old] = cy;
            ring_w[s][old]  = w;   ring_h[s][old]  = h;
            ring_cx[s][pos] = cx;  ring_cy[s][pos] = cy;
            ring_w[s][pos]  = w;   ring_h[s][pos]  = h;
            ring_oldest[s]  = (old + 1) % DEPTH;
        end
        else
        begin
            pos = (old + fill) % DEPTH;
            ring_cx[s][pos] = cx;  ring_cy[s][pos] = cy;
            ring_w[s][pos]  = w;   ring_h[s][pos]  = h;
            ring_fill[s]    = fill + 1;
        end
        return 17'(weight);
    endfunction

    // Mostly short gaps, a few long ones; none at all while dense mode is on.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (dense_mode || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Driver: an item is accepted at an edge with in_valid high and in_stall low.
    // The expected weight is computed right there, so it sees the configuration
    // that is in force when the block takes the item.
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        box_item_t    it;
        weight_item_t exp_w;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            mode       <= MODE_UPDATE;
            track_slot <= '0;
            left_x     <= '0;
            top_y      <= '0;
            right_x    <= '0;
            bottom_y   <= '0;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                it.mode = mode;
                it.slot = track_slot;
                it.lx   = left_x;
                it.ty   = top_y;
                it.rx   = right_x;
                it.by   = bottom_y;
                exp_w.slot   = track_slot;
                exp_w.weight = blend_for_box(it);
                expected_weights = {expected_weights, exp_w};
                accepted_count++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_boxes.size() > 0)
                begin
                    it = pending_boxes[0];
                    pending_boxes.delete(0);
                    in_valid   <= 1'b1;
                    mode       <= it.mode;
                    track_slot <= it.slot;
                    left_x     <= it.lx;
                    top_y      <= it.ty;
                    right_x    <= it.rx;
                    bottom_y   <= it.by;
                    gap_left   <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off after the hundredth result
    // while the driver keeps offering items, so the block backs up into in_stall.
    int  hold_left;
    bit  hold_done;
    always @(posedge clk or negedge rst_n)
    begin
        int r;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && result_count >= 100)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (dense_mode)
                out_stall <= 1'b0;
            else if (r < 65)
                out_stall <= 1'b0;
            else if (r < 95)
                out_stall <= 1'b1;
            else
            begin
                out_stall <= 1'b1;
                hold_left <= $urandom_range(5, 25);
            end
        end
    end

    // Monitor and watchdog. Results are compared with the oldest expectation.
    always @(posedge clk)
    begin
        weight_item_t exp_w;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (expected_weights.size() == 0)
                begin
                    $error("result with no item waiting: slot %0d weight %0d",
                           slot_echo, blend_weight);
                    error_count++;
                end
                else
                begin
                    exp_w = expected_weights[0];
                    expected_weights.delete(0);
                    if (slot_echo !== exp_w.slot)
                    begin
                        $error("slot_echo: expected %0d, actual %0d",
                               exp_w.slot, slot_echo);
                        error_count++;
                    end
                    if (blend_weight !== exp_w.weight)
                    begin
                        $error("blend_weight: expected %0d, actual %0d",
                               exp_w.weight, blend_weight);
                        error_count++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG)
            begin
                $display("FAIL box_motion_anomaly_alpha");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic reg_write(int index, int value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bma_pkg::APB_AW'(4 * index);
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_ENABLE:    shadow_en      = value[0];
            REG_REDUCED:   shadow_reduced = value & 32'h1FFFF;
            REG_THRESHOLD: shadow_thresh  = value & 32'hFFFF;
            REG_SHRINK:    shadow_shrink  = value & 32'hFFFF;
            REG_LENGTH:    shadow_length  = value & 32'h1F;
            default:       ;
        endcase
    endtask

    task automatic set_config(int en, int reduced, int thresh, int shrink, int len);
        reg_write(REG_ENABLE, en);
        reg_write(REG_REDUCED, reduced);
        reg_write(REG_THRESHOLD, thresh);
        reg_write(REG_SHRINK, shrink);
        reg_write(REG_LENGTH, len);
    endtask

    // Waits until every queued item is in and every weight is out, then lets
    // the longest latency pass so the block is surely idle.
    task automatic drain();
        while (accepted_count != queued_count || expected_weights.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_box(logic m, int s, int lx, int ty, int rx, int by);
        box_item_t it;
        it.mode = m;
        it.slot = 6'(s);
        it.lx   = 16'(lx);
        it.ty   = 16'(ty);
        it.rx   = 16'(rx);
        it.by   = 16'(by);
        pending_boxes = {pending_boxes, it};
        queued_count++;
    endtask

    function automatic int clip16(int v);
        return v < 0 ? 0 : (v > 65535 ? 65535 : v);
    endfunction

    // Tracks that move smoothly with random content make up most of the random
    // part; the rest is jumps, shrinking boxes, clears and arbitrary boxes.
    int trk_x[8];
    int trk_y[8];
    int trk_w[8];
    int trk_h[8];
    task automatic random_items(int count);
        int s;
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
                send_box(MODE_CLEAR, $urandom_range(0, 63), $urandom, $urandom,
                         $urandom, $urandom);
            else if (r < 18)
                send_box(MODE_UPDATE, $urandom_range(0, 63), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 65535));
            else
            begin
                s = $urandom_range(0, 7);
                trk_x[s] = clip16(trk_x[s] + $urandom_range(0, 80) - 40);
                trk_y[s] = clip16(trk_y[s] + $urandom_range(0, 80) - 40);
                trk_w[s] = clip16(trk_w[s] + $urandom_range(0, 16) - 8);
                trk_h[s] = clip16(trk_h[s] + $urandom_range(0, 16) - 8);
                if (r < 28)
                begin
                    trk_x[s] = $urandom_range(0, 60000);
                    trk_y[s] = $urandom_range(0, 60000);
                end
                else if (r < 36)
                begin
                    trk_w[s] = trk_w[s] / 4;
                    trk_h[s] = trk_h[s] / 3;
                end
                else if (r < 40)
                begin
                    trk_w[s] = $urandom_range(0, 5000);
                    trk_h[s] = $urandom_range(0, 5000);
                end
                send_box(MODE_UPDATE, s, trk_x[s], trk_y[s],
                         clip16(trk_x[s] + trk_w[s]), clip16(trk_y[s] + trk_h[s]));
            end
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        dense_mode     = 1'b0;
        queued_count   = 0;
        accepted_count = 0;
        result_count   = 0;
        error_count    = 0;
        idle_cycles    = 0;
        shadow_en      = 1'b0;
        shadow_reduced = 32768;
        shadow_thresh  = 512;
        shadow_shrink  = 256;
        shadow_length  = 8;
        for (int s = 0; s < SLOTS; s++)
        begin
            ring_fill[s]   = 0;
            ring_oldest[s] = 0;
        end
        for (int s = 0; s < 8; s++)
        begin
            trk_x[s] = $urandom_range(1000, 50000);
            trk_y[s] = $urandom_range(1000, 50000);
            trk_w[s] = $urandom_range(200, 4000);
            trk_h[s] = $urandom_range(200, 4000);
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration: smoothing is off, every weight is full and the
        // histories stay empty.
        send_box(MODE_UPDATE, 0, 0, 0, 65535, 65535);
        send_box(MODE_UPDATE, 63, 65535, 65535, 0, 0);
        send_box(MODE_CLEAR, 5, 1, 2, 3, 4);
        drain();

        set_config(1, 32768, 512, 256, 8);
        // Steady motion on slot 1, then a jump in center, then a jump in size.
        send_box(MODE_UPDATE, 1, 100, 100, 200, 200);
        send_box(MODE_UPDATE, 1, 110, 100, 210, 200);
        send_box(MODE_UPDATE, 1, 120, 100, 220, 200);
        send_box(MODE_UPDATE, 1, 5000, 100, 5100, 200);
        send_box(MODE_UPDATE, 1, 5010, 100, 5300, 150);
        send_box(MODE_UPDATE, 1, 5020, 100, 5110, 120);
        // Slot 2 never moves, so its mean step is zero and any step counts.
        send_box(MODE_UPDATE, 2, 40, 40, 80, 80);
        send_box(MODE_UPDATE, 2, 40, 40, 80, 80);
        send_box(MODE_UPDATE, 2, 40, 40, 80, 80);
        send_box(MODE_UPDATE, 2, 41, 40, 81, 80);
        // Inverted boxes give negative sizes and areas.
        send_box(MODE_UPDATE, 3, 65535, 65535, 0, 0);
        send_box(MODE_UPDATE, 3, 60000, 0, 100, 65535);
        send_box(MODE_UPDATE, 3, 0, 65535, 65535, 0);
        send_box(MODE_UPDATE, 3, 0, 0, 65535, 65535);
        // Clear mode, then the slot starts over with a short history.
        send_box(MODE_CLEAR, 1, 0, 0, 0, 0);
        send_box(MODE_UPDATE, 1, 300, 300, 400, 400);
        send_box(MODE_UPDATE, 1, 65535, 65535, 65535, 65535);
        send_box(MODE_UPDATE, 63, 0, 0, 0, 0);
        drain();

        dense_mode = 1'b1;
        random_items(60);
        drain();
        dense_mode = 1'b0;
        random_items(70);
        drain();

        // Low extremes: weight zero, no tolerance, ratio zero, one box kept.
        set_config(1, 0, 0, 0, 1);
        random_items(50);
        drain();

        // High extremes, and history lowered afterwards to test the drop path.
        set_config(1, 65535, 65535, 65535, 16);
        random_items(80);
        drain();
        reg_write(REG_LENGTH, 2);
        reg_write(REG_THRESHOLD, 128);
        reg_write(REG_SHRINK, 512);
        random_items(50);
        drain();

        // Lengths out of range are clamped.
        set_config(1, 20000, 300, 200, 0);
        random_items(40);
        drain();
        reg_write(REG_LENGTH, 31);
        random_items(60);
        drain();

        // Full reduced weight disables, as does enable low.
        reg_write(REG_REDUCED, 65536);
        random_items(20);
        drain();
        set_config(0, 1000, 512, 256, 8);
        random_items(20);
        drain();

        if (error_count == 0)
            $display("PASS box_motion_anomaly_alpha");
        else
            $display("FAIL box_motion_anomaly_alpha");
        $finish;
    end

endmodule
